@@ src/bcs_pkg.sv @@
package bcs_pkg;

   // Default sequencing parameters
   localparam int unsigned DEF_STABLE_SAMPLES = 10;
   localparam int unsigned DEF_UNKNOWN_HOLD   = 70;
   localparam int unsigned DEF_ERROR_HOLD     = 100;
   localparam int unsigned DEF_CELLS          = 6;

   // Cell inputs carried by one sample
   localparam int unsigned MAX_CELLS = 6;

   // Cell detection thresholds
   localparam logic signed [15:0] CELL_PRESENT_MV   = 16'sd2000;
   localparam logic [10:0]        CELL_TOLERANCE_MV = 11'd300;

   // Divide by ten: floor(x * 52429 / 2^19) is exact for 15-bit x
   localparam logic [15:0] DIV10_MULT  = 16'd52429;
   localparam int unsigned DIV10_SHIFT = 19;

   // Charger modes; any other code means stop
   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_MANUAL = 2'd1;

   // Register indexes
   localparam logic [1:0] CSR_CELL_TARGET  = 2'd0;
   localparam logic [1:0] CSR_CHARGE_CURR  = 2'd1;
   localparam logic [1:0] CSR_MANUAL_CELLS = 2'd2;

   // Reset values of the registers
   localparam logic [12:0] RST_CELL_TARGET  = 13'd3850;
   localparam logic [14:0] RST_CHARGE_CURR  = 15'd1000;
   localparam logic [2:0]  RST_MANUAL_CELLS = 3'd6;

   typedef struct packed {
      logic [1:0]         mode;
      logic [14:0]        pack_voltage_mv;
      logic signed [15:0] pack_current_ma;
      logic signed [15:0] cell0_mv;
      logic signed [15:0] cell1_mv;
      logic signed [15:0] cell2_mv;
      logic signed [15:0] cell3_mv;
      logic signed [15:0] cell4_mv;
      logic signed [15:0] cell5_mv;
      logic               balancer_done;
   } req_item_type;

   typedef struct packed {
      logic [2:0] charge_state;
      logic [2:0] active_cells;
      logic [2:0] detected_cells;
      logic       clear_counters;
      logic       request_stop;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [14:0] value;
   } csr_item_type;

endpackage

@@ src/bcs_chan_if.sv @@
interface bcs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/battery_charge_state_sequencer.sv @@
// Battery charge state sequencer. Each req beat is one sample period (mode, pack
// voltage and current, six cell voltages, balancer-done flag); each produces exactly
// one rsp beat with the charge state after that sample, the latched cell count, the
// cell count detected in the sample and the clear_counters / request_stop pulses.
// One beat per cycle is sustained while rsp ready stays high: a beat lands in an
// input register, one pass of shallow logic (cell count and pack check, state
// update) feeds the result register, which drives rsp. While a finished result
// waits for rsp ready, the input register takes one more beat and then holds req
// ready low. The csr channel is always
// ready; write registers only while no sample is in flight. Register 0 is the
// per-cell end-of-charge voltage, 1 the charge current setpoint (full below a tenth
// of it), 2 the manual-mode cell count (zero never matches).
module battery_charge_state_sequencer #(
   parameter int unsigned STABLE_SAMPLES = bcs_pkg::DEF_STABLE_SAMPLES,
   parameter int unsigned UNKNOWN_HOLD   = bcs_pkg::DEF_UNKNOWN_HOLD,
   parameter int unsigned ERROR_HOLD     = bcs_pkg::DEF_ERROR_HOLD,
   parameter int unsigned CELLS          = bcs_pkg::DEF_CELLS
) (
   input logic        clock,
   input logic        reset,
   bcs_chan_if.sink   req_bus,
   bcs_chan_if.source rsp_bus,
   bcs_chan_if.sink   csr_bus
);

   // Phase codes
   localparam logic [2:0] PH_WAITING  = 3'd0;
   localparam logic [2:0] PH_CHARGING = 3'd1;
   localparam logic [2:0] PH_FULL     = 3'd2;
   localparam logic [2:0] PH_UNKNOWN  = 3'd3;
   localparam logic [2:0] PH_ERROR    = 3'd4;

   // Counter widths follow from the hold and run lengths
   localparam int unsigned MAX_HOLD = (UNKNOWN_HOLD > ERROR_HOLD) ? UNKNOWN_HOLD : ERROR_HOLD;
   localparam int unsigned TW = $clog2(MAX_HOLD + 1);
   localparam int unsigned RW = $clog2(STABLE_SAMPLES + 1);

   // ---------------------------------------------------------------- registers
   logic [12:0] cell_target_ff;
   logic [14:0] charge_curr_ff;
   logic [2:0]  manual_cells_ff;

   logic                  s1_valid_ff, s1_valid_in;
   bcs_pkg::req_item_type s1_item_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   bcs_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic [2:0]    phase_ff, phase_in;
   logic [2:0]    latched_ff, latched_in;
   logic [2:0]    prev_count_ff;
   logic [RW-1:0] run_ff, run_in;
   logic [TW-1:0] timer_ff, timer_in;

   // ---------------------------------------------------------------- handshakes
   logic req_take;
   logic advance;

   // Move the held sample on when the result register is free or being drained
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take    = req_bus.valid && req_bus.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_item_ff;

   // ---------------------------------------------------------------- cell detection
   logic signed [15:0] cell_mv [bcs_pkg::MAX_CELLS];
   logic [17:0]        cell_sum;
   logic [2:0]         cell_count;
   logic [17:0]        pack_diff;
   logic [10:0]        tolerance;
   logic [2:0]         det;

   assign cell_mv[0] = s1_item_ff.cell0_mv;
   assign cell_mv[1] = s1_item_ff.cell1_mv;
   assign cell_mv[2] = s1_item_ff.cell2_mv;
   assign cell_mv[3] = s1_item_ff.cell3_mv;
   assign cell_mv[4] = s1_item_ff.cell4_mv;
   assign cell_mv[5] = s1_item_ff.cell5_mv;

   // Sum and count the cells above the presence threshold
   always_comb begin
      cell_sum   = '0;
      cell_count = '0;
      for (int i = 0; i < int'(CELLS); i++) begin
         if (cell_mv[i] > bcs_pkg::CELL_PRESENT_MV) begin
            cell_sum   = cell_sum + {3'b000, cell_mv[i][14:0]};
            cell_count = cell_count + 3'd1;
         end
      end
   end

   // Accept the count only if the cell sum matches the pack within tolerance
   assign pack_diff = (cell_sum >= {3'b000, s1_item_ff.pack_voltage_mv})
                    ? cell_sum - {3'b000, s1_item_ff.pack_voltage_mv}
                    : {3'b000, s1_item_ff.pack_voltage_mv} - cell_sum;
   assign tolerance = {8'd0, cell_count} * bcs_pkg::CELL_TOLERANCE_MV;
   assign det       = (pack_diff < {7'd0, tolerance}) ? cell_count : 3'd0;

   // ---------------------------------------------------------------- end-of-charge test
   logic [30:0] curr_scaled;
   logic [11:0] curr_limit;
   logic [15:0] full_mv;
   logic        is_full;
   logic        is_stop;

   assign curr_scaled = 31'({16'd0, charge_curr_ff} * {15'd0, bcs_pkg::DIV10_MULT});
   assign curr_limit  = curr_scaled[30:bcs_pkg::DIV10_SHIFT];
   assign full_mv     = {3'b000, cell_target_ff} * {13'd0, latched_ff};
   assign is_full     = ({1'b0, s1_item_ff.pack_voltage_mv} >= full_mv)
                     && (s1_item_ff.pack_current_ma < $signed({4'd0, curr_limit}))
                     && s1_item_ff.balancer_done;
   assign is_stop     = (s1_item_ff.mode != bcs_pkg::MODE_AUTO)
                     && (s1_item_ff.mode != bcs_pkg::MODE_MANUAL);

   // ---------------------------------------------------------------- sequencer
   logic [TW:0] timer_inc;
   logic [RW:0] run_inc;
   logic        clr;
   logic        stop_req;

   assign timer_inc = {1'b0, timer_ff} + {{TW{1'b0}}, 1'b1};
   assign run_inc   = {1'b0, run_ff} + {{RW{1'b0}}, 1'b1};

   always_comb begin
      phase_in   = phase_ff;
      latched_in = latched_ff;
      timer_in   = timer_ff;
      run_in     = '0;
      clr        = 1'b0;
      stop_req   = 1'b0;
      case (phase_ff)
         PH_CHARGING: begin
            if (is_stop) begin
               phase_in = PH_WAITING;
            end else begin
               if (is_full) begin
                  phase_in = PH_FULL;
               end
               // A changed pack overrides the full decision
               if (det != latched_ff) begin
                  latched_in = 3'd0;
                  phase_in   = PH_UNKNOWN;
                  timer_in   = '0;
               end
            end
         end
         PH_FULL: begin
            if (det != latched_ff) begin
               latched_in = 3'd0;
               phase_in   = PH_UNKNOWN;
               timer_in   = '0;
            end
         end
         PH_UNKNOWN: begin
            timer_in = timer_inc[TW-1:0];
            if (timer_inc >= (TW+1)'(UNKNOWN_HOLD)) begin
               timer_in = '0;
               phase_in = PH_WAITING;
            end
         end
         PH_ERROR: begin
            timer_in = timer_inc[TW-1:0];
            if (timer_inc >= (TW+1)'(ERROR_HOLD)) begin
               timer_in = '0;
               phase_in = PH_WAITING;
               stop_req = 1'b1;
            end
         end
         default: begin
            phase_in = PH_WAITING;
            if (s1_item_ff.mode == bcs_pkg::MODE_AUTO) begin
               // Extend the run on a repeated count, restart it on a new one
               if (det == 3'd0) begin
                  run_in = '0;
               end else if (det == prev_count_ff) begin
                  run_in = (run_inc >= (RW+1)'(STABLE_SAMPLES))
                         ? RW'(STABLE_SAMPLES) : run_inc[RW-1:0];
               end else begin
                  run_in = RW'(1);
               end
               if ((det != 3'd0) && (run_in >= RW'(STABLE_SAMPLES))) begin
                  latched_in = det;
                  phase_in   = PH_CHARGING;
                  clr        = 1'b1;
                  run_in     = '0;
               end
            end else if (s1_item_ff.mode == bcs_pkg::MODE_MANUAL) begin
               if ((manual_cells_ff != 3'd0) && (det == manual_cells_ff)) begin
                  latched_in = manual_cells_ff;
                  phase_in   = PH_CHARGING;
                  clr        = 1'b1;
               end else begin
                  phase_in = PH_ERROR;
                  timer_in = '0;
               end
            end
         end
      endcase
   end

   always_comb begin
      rsp_item_in.charge_state   = phase_in;
      rsp_item_in.active_cells   = latched_in;
      rsp_item_in.detected_cells = det;
      rsp_item_in.clear_counters = clr;
      rsp_item_in.request_stop   = stop_req;
   end

   // ---------------------------------------------------------------- clocked
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_target_ff  <= bcs_pkg::RST_CELL_TARGET;
         charge_curr_ff  <= bcs_pkg::RST_CHARGE_CURR;
         manual_cells_ff <= bcs_pkg::RST_MANUAL_CELLS;
      end else if (csr_bus.valid) begin
         case (csr_bus.data.index)
            bcs_pkg::CSR_CELL_TARGET:  cell_target_ff  <= csr_bus.data.value[12:0];
            bcs_pkg::CSR_CHARGE_CURR:  charge_curr_ff  <= csr_bus.data.value;
            bcs_pkg::CSR_MANUAL_CELLS: manual_cells_ff <= csr_bus.data.value[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_WAITING;
         latched_ff    <= 3'd0;
         prev_count_ff <= 3'd0;
         run_ff        <= '0;
         timer_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff      <= phase_in;
            latched_ff    <= latched_in;
            prev_count_ff <= det;
            run_ff        <= run_in;
            timer_ff      <= timer_in;
         end
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_bus.data;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

`ifndef SYNTH
   a_clear_starts_charge: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.clear_counters |->
         rsp_bus.data.charge_state == PH_CHARGING
         && rsp_bus.data.active_cells == rsp_bus.data.detected_cells
         && rsp_bus.data.active_cells != 3'd0)
      else $error("clear_counters without a valid charge start");

   a_stop_leaves_error: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.request_stop |->
         rsp_bus.data.charge_state == PH_WAITING && !rsp_bus.data.clear_counters)
      else $error("request_stop outside the return from error");

   a_charging_has_cells: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CHARGING || phase_ff == PH_FULL) |-> latched_ff != 3'd0)
      else $error("charging or full with no latched cells");

   a_unknown_clears_cells: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_UNKNOWN |-> latched_ff == 3'd0)
      else $error("unknown phase kept a latched cell count");
`endif

endmodule

@@ test/battery_charge_state_sequencer_tb.sv @@
`timescale 1ns / 1ps

module battery_charge_state_sequencer_tb;

   // Charge phase codes as they appear on rsp charge_state
   localparam logic [2:0] PHASE_WAITING  = 3'd0;
   localparam logic [2:0] PHASE_CHARGING = 3'd1;
   localparam logic [2:0] PHASE_FULL     = 3'd2;
   localparam logic [2:0] PHASE_UNKNOWN  = 3'd3;
   localparam logic [2:0] PHASE_ERROR    = 3'd4;

   // Mode codes the package leaves implicit: both of these mean stop
   localparam logic [1:0] MODE_STOP     = 2'd2;
   localparam logic [1:0] MODE_STOP_ALT = 2'd3;

   localparam int unsigned IDLE_PCT      = 7;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned PHASE_ITEMS   = 165;

   // Tracks the sequencer: every accepted sample pushes its expected status,
   // every rsp beat is checked against the oldest one.
   class charge_scoreboard;
      bcs_pkg::rsp_item_type pending_status[$];
      int unsigned  errors;
      int unsigned  target_mv;
      int unsigned  charge_ma;
      int unsigned  manual_cells;
      logic [2:0]   phase;
      logic [2:0]   latched;
      logic [2:0]   prev_count;
      int unsigned  stable_run;
      int unsigned  hold_timer;

      function new();
         errors       = 0;
         target_mv    = bcs_pkg::RST_CELL_TARGET;
         charge_ma    = bcs_pkg::RST_CHARGE_CURR;
         manual_cells = bcs_pkg::RST_MANUAL_CELLS;
         phase        = PHASE_WAITING;
         latched      = '0;
         prev_count   = '0;
         stable_run   = 0;
         hold_timer   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [14:0] val);
         case (idx)
            bcs_pkg::CSR_CELL_TARGET:  target_mv    = val[12:0];
            bcs_pkg::CSR_CHARGE_CURR:  charge_ma    = val;
            bcs_pkg::CSR_MANUAL_CELLS: manual_cells = val[2:0];
            default: ;
         endcase
      endfunction

      function logic [2:0] count_cells(bcs_pkg::req_item_type s);
         logic signed [15:0] cell_mv [6];
         int sum;
         int diff;
         int n;
         cell_mv = '{s.cell0_mv, s.cell1_mv, s.cell2_mv,
                     s.cell3_mv, s.cell4_mv, s.cell5_mv};
         sum  = 0;
         n    = 0;
         for (int i = 0; i < bcs_pkg::DEF_CELLS && i < bcs_pkg::MAX_CELLS; i++) begin
            if (cell_mv[i] > bcs_pkg::CELL_PRESENT_MV) begin
               sum += cell_mv[i];
               n++;
            end
         end
         diff = sum - int'(s.pack_voltage_mv);
         if (diff < 0) diff = -diff;
         return (diff < int'(bcs_pkg::CELL_TOLERANCE_MV) * n) ? n[2:0] : 3'd0;
      endfunction

      function void note_sample(bcs_pkg::req_item_type s);
         logic [2:0]   det;
         logic         clr;
         logic         stp;
         int unsigned  run;
         int           cur;
         bit           stop_mode;
         bcs_pkg::rsp_item_type r;
         det       = count_cells(s);
         clr       = 1'b0;
         stp       = 1'b0;
         run       = 0;
         cur       = $signed(s.pack_current_ma);
         stop_mode = (s.mode != bcs_pkg::MODE_AUTO) && (s.mode != bcs_pkg::MODE_MANUAL);
         case (phase)
            PHASE_CHARGING: begin
               if (stop_mode) begin
                  phase = PHASE_WAITING;
               end else begin
                  if (s.pack_voltage_mv >= target_mv * latched &&
                      cur < int'(charge_ma / 10) && s.balancer_done)
                     phase = PHASE_FULL;
                  // a changed pack overrides a full decision in the same sample
                  if (det != latched) begin
                     latched    = '0;
                     phase      = PHASE_UNKNOWN;
                     hold_timer = 0;
                  end
               end
            end
            PHASE_FULL: begin
               if (det != latched) begin
                  latched    = '0;
                  phase      = PHASE_UNKNOWN;
                  hold_timer = 0;
               end
            end
            PHASE_UNKNOWN: begin
               hold_timer++;
               if (hold_timer >= bcs_pkg::DEF_UNKNOWN_HOLD) begin
                  hold_timer = 0;
                  phase      = PHASE_WAITING;
               end
            end
            PHASE_ERROR: begin
               hold_timer++;
               if (hold_timer >= bcs_pkg::DEF_ERROR_HOLD) begin
                  hold_timer = 0;
                  phase      = PHASE_WAITING;
                  stp        = 1'b1;
               end
            end
            default: begin
               phase = PHASE_WAITING;
               if (s.mode == bcs_pkg::MODE_AUTO) begin
                  if (det == 0)
                     run = 0;
                  else if (det == prev_count)
                     run = (stable_run + 1 >= bcs_pkg::DEF_STABLE_SAMPLES) ?
                           bcs_pkg::DEF_STABLE_SAMPLES : stable_run + 1;
                  else
                     run = 1;
                  if (det != 0 && run >= bcs_pkg::DEF_STABLE_SAMPLES) begin
                     latched = det;
                     phase   = PHASE_CHARGING;
                     clr     = 1'b1;
                     run     = 0;
                  end
               end else if (s.mode == bcs_pkg::MODE_MANUAL) begin
                  if (manual_cells > 0 && det == manual_cells) begin
                     latched = manual_cells[2:0];
                     phase   = PHASE_CHARGING;
                     clr     = 1'b1;
                  end else begin
                     phase      = PHASE_ERROR;
                     hold_timer = 0;
                  end
               end
            end
         endcase
         stable_run = run;
         prev_count = det;

         r.charge_state   = phase;
         r.active_cells   = latched;
         r.detected_cells = det;
         r.clear_counters = clr;
         r.request_stop   = stp;
         pending_status.push_back(r);
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(bcs_pkg::rsp_item_type got);
         bcs_pkg::rsp_item_type want;
         if (pending_status.size() == 0) begin
            $error("rsp beat with no sample outstanding: %p", got);
            errors++;
            return;
         end
         want = pending_status.pop_front();
         check_field("charge_state", want.charge_state, got.charge_state);
         check_field("active_cells", want.active_cells, got.active_cells);
         check_field("detected_cells", want.detected_cells, got.detected_cells);
         check_field("clear_counters", want.clear_counters, got.clear_counters);
         check_field("request_stop", want.request_stop, got.request_stop);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bcs_chan_if #(.payload_type(bcs_pkg::req_item_type)) req_bus();
   bcs_chan_if #(.payload_type(bcs_pkg::rsp_item_type)) rsp_bus();
   bcs_chan_if #(.payload_type(bcs_pkg::csr_item_type)) csr_bus();

   battery_charge_state_sequencer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   charge_scoreboard sb = new();

   // Settings as last written; the sample builders aim at them
   int unsigned cfg_target = bcs_pkg::RST_CELL_TARGET;
   int unsigned cfg_charge = bcs_pkg::RST_CHARGE_CURR;
   int unsigned cfg_manual = bcs_pkg::RST_MANUAL_CELLS;

   bit          quiet = 1'b0;     // suppress idling on both sides
   int unsigned sent_count = 0;
   int unsigned stalled_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample every handshake at the edge; drivers only change things after it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_sample(req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) sb.check_result(rsp_bus.data);
         if (csr_bus.valid && csr_bus.ready)
            sb.write_reg(csr_bus.data.index, csr_bus.data.value);
      end
   end

   // Drop rsp ready at random about 7 percent of the time, never while quiet.
   always @(posedge clock) begin
      rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Abort when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // Offer one sample, idling first at random; return at the edge that takes it
   // with valid still high, so a following beat can go out back to back.
   task automatic send_sample(input bcs_pkg::req_item_type s);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= s;
      do @(posedge clock); while (!req_bus.ready);
      sent_count++;
   endtask

   // Hold off until every status has come back, then let the pipe settle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back; call only with the block idle.
   task automatic write_settings(input int unsigned tgt, input int unsigned cur,
                                 input int unsigned cells);
      bcs_pkg::csr_item_type w [3];
      w[0].index = bcs_pkg::CSR_CELL_TARGET;
      w[0].value = 15'(tgt);
      w[1].index = bcs_pkg::CSR_CHARGE_CURR;
      w[1].value = 15'(cur);
      w[2].index = bcs_pkg::CSR_MANUAL_CELLS;
      w[2].value = 15'(cells);
      for (int i = 0; i < 3; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.data  <= w[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      cfg_target = tgt;
      cfg_charge = cur;
      cfg_manual = cells;
   endtask

   function automatic bcs_pkg::req_item_type flat_sample(input logic [1:0] md,
                                                input logic signed [15:0] cell_v,
                                                input int pack, input int cur,
                                                input bit bal);
      bcs_pkg::req_item_type s;
      s.mode            = md;
      s.pack_voltage_mv = pack[14:0];
      s.pack_current_ma = cur[15:0];
      s.cell0_mv        = cell_v;
      s.cell1_mv        = cell_v;
      s.cell2_mv        = cell_v;
      s.cell3_mv        = cell_v;
      s.cell4_mv        = cell_v;
      s.cell5_mv        = cell_v;
      s.balancer_done   = bal;
      return s;
   endfunction

   // Build a sample with n present cells in random slots. near_full puts the
   // cells at the target and the current under the cutoff; bad_pack moves the
   // pack voltage out of tolerance so the count is rejected.
   function automatic bcs_pkg::req_item_type make_sample(input logic [1:0] md, input int n,
                                                input bit near_full, input bit bad_pack);
      bcs_pkg::req_item_type s;
      logic signed [15:0] cv [6];
      bit [5:0]           used;
      int                 slot;
      int                 base;
      int                 v;
      int                 sum;
      int                 lim;
      int                 off;
      int                 pk;
      int                 cur;
      used = '0;
      sum  = 0;
      for (int k = 0; k < n; k++) begin
         do slot = $urandom_range(0, 5); while (used[slot]);
         used[slot] = 1'b1;
      end
      base = (near_full && cfg_target > 2000) ? int'(cfg_target) : 2001;
      for (int i = 0; i < 6; i++) begin
         if (used[i]) begin
            v = base + int'(near_full ? $urandom_range(0, 150) : $urandom_range(0, 2200));
            sum += v;
         end else begin
            case ($urandom_range(0, 3))
               0:       v = 2000;
               1:       v = $urandom_range(0, 2000);
               2:       v = int'($urandom_range(0, 32768)) - 32768;
               default: v = $urandom_range(0, 1999);
            endcase
         end
         cv[i] = v[15:0];
      end
      lim = 300 * n - 1;
      if (bad_pack) begin
         off = 300 * n + int'($urandom_range(0, 2000));
         if ($urandom_range(0, 1)) off = -off;
      end else if (n == 0) begin
         off = $urandom_range(0, 3000);
      end else if (near_full) begin
         off = $urandom_range(0, lim);
      end else begin
         off = int'($urandom_range(0, 2 * lim)) - lim;
      end
      pk = sum + off;
      if (pk < 0) pk = 0;
      if (pk > 32767) pk = 32767;
      if (near_full)
         cur = int'(cfg_charge / 10) - 1 - int'($urandom_range(0, 300));
      else
         cur = int'(cfg_charge / 10) + int'($urandom_range(0, 3000));
      if (cur > 32767) cur = 32767;

      s.mode            = md;
      s.pack_voltage_mv = pk[14:0];
      s.pack_current_ma = cur[15:0];
      s.cell0_mv        = cv[0];
      s.cell1_mv        = cv[1];
      s.cell2_mv        = cv[2];
      s.cell3_mv        = cv[3];
      s.cell4_mv        = cv[4];
      s.cell5_mv        = cv[5];
      s.balancer_done   = near_full ? 1'b1 : 1'($urandom_range(0, 1));
      return s;
   endfunction

   // Every field, every bit, uniformly random
   function automatic bcs_pkg::req_item_type random_sample();
      logic [159:0] bits;
      bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return bits[$bits(bcs_pkg::req_item_type)-1:0];
   endfunction

   // Keep charging a while, then end the session one of four ways:
   // reach full and lose the pack, stop, change count, or break the pack check.
   task automatic charge_session(input int n);
      int other;
      other = (n < bcs_pkg::MAX_CELLS) ? n + 1
                                       : int'($urandom_range(0, bcs_pkg::MAX_CELLS - 1));
      repeat ($urandom_range(0, 8))
         send_sample(make_sample(2'($urandom_range(0, 1)), n, 1'b0, 1'b0));
      case ($urandom_range(0, 3))
         0: begin
            send_sample(make_sample(2'($urandom_range(0, 1)), n, 1'b1, 1'b0));
            repeat ($urandom_range(1, 5))
               send_sample(make_sample(2'($urandom_range(0, 3)), n,
                                       1'($urandom_range(0, 1)), 1'b0));
            send_sample(make_sample(2'($urandom_range(0, 3)), other, 1'b0, 1'b0));
         end
         1: send_sample(make_sample(MODE_STOP, n, 1'b0, 1'b0));
         // count change with the full condition met in the same sample
         2: send_sample(make_sample(2'($urandom_range(0, 1)), other, 1'b1, 1'b0));
         default: send_sample(make_sample(2'($urandom_range(0, 1)), n, 1'b0, 1'b1));
      endcase
   endtask

   task automatic run_session();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         // auto start: a stable run of equal counts, now and then a broken sample
         n = $urandom_range(1, bcs_pkg::MAX_CELLS);
         repeat (bcs_pkg::DEF_STABLE_SAMPLES + $urandom_range(0, 3))
            send_sample(make_sample(bcs_pkg::MODE_AUTO, n, 1'b0,
                                    $urandom_range(0, 14) == 0));
         charge_session(n);
      end else if (pick < 55) begin
         // manual start, mostly with the count the user set
         n = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, bcs_pkg::MAX_CELLS))
                                         : int'(cfg_manual);
         send_sample(make_sample(bcs_pkg::MODE_MANUAL, n, 1'b0, 1'b0));
         charge_session(n);
      end else if (pick < 75) begin
         // long filler, mostly stop mode, so unknown and error holds run out
         repeat ($urandom_range(1, 110))
            send_sample(make_sample(($urandom_range(0, 3) == 0) ?
                                    2'($urandom_range(0, 3)) : MODE_STOP,
                                    $urandom_range(0, bcs_pkg::MAX_CELLS), 1'b0,
                                    $urandom_range(0, 7) == 0));
      end else begin
         repeat ($urandom_range(1, 8)) send_sample(random_sample());
      end
   endtask

   initial begin
      int unsigned  budget;
      bcs_pkg::req_item_type s;

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed samples under the reset settings
      send_sample(flat_sample(MODE_STOP, 16'sd0, 0, 0, 1'b0));
      send_sample(make_sample(MODE_STOP_ALT, 6, 1'b0, 1'b0));
      // pack tolerance edges: one millivolt inside, then exactly on the limit
      send_sample(flat_sample(MODE_STOP, 16'sd3000, 18000 + 1799, 50, 1'b0));
      send_sample(flat_sample(MODE_STOP, 16'sd3000, 18000 - 1800, 50, 1'b0));
      // a cell at exactly 2000 mV is absent, 2001 mV is present
      s = flat_sample(MODE_STOP, 16'sd0, 4002, 0, 1'b0);
      s.cell0_mv = 16'sd2001;
      s.cell1_mv = 16'sd2000;
      s.cell2_mv = 16'sd2001;
      s.cell4_mv = 16'shFFFF;
      s.cell5_mv = 16'sh8000;
      send_sample(s);
      send_sample(flat_sample(MODE_STOP, 16'sh7FFF, 32767, 32767, 1'b0));
      send_sample(flat_sample(MODE_STOP, 16'sh8000, 0, -32768, 1'b1));
      // manual start, stop while charging, restart, full, full ignores stop,
      // then a changed count
      send_sample(make_sample(bcs_pkg::MODE_MANUAL, 6, 1'b0, 1'b0));
      send_sample(make_sample(bcs_pkg::MODE_AUTO, 6, 1'b0, 1'b0));
      send_sample(make_sample(MODE_STOP, 6, 1'b0, 1'b0));
      send_sample(make_sample(bcs_pkg::MODE_MANUAL, 6, 1'b0, 1'b0));
      send_sample(make_sample(bcs_pkg::MODE_MANUAL, 6, 1'b1, 1'b0));
      send_sample(make_sample(MODE_STOP, 6, 1'b1, 1'b0));
      send_sample(make_sample(bcs_pkg::MODE_AUTO, 5, 1'b0, 1'b0));

      // Random sessions in five setting phases; the fourth runs without idling
      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            drain_results();
            case (ph)
               1: write_settings(5000, 32767, 0);
               2: write_settings(0, 0, 1);
               3: write_settings(4200, 1500, 3);
               default: write_settings($urandom_range(0, 5000), $urandom_range(0, 32767),
                                       $urandom_range(0, bcs_pkg::MAX_CELLS));
            endcase
         end
         quiet  = (ph == 3);
         budget = sent_count + PHASE_ITEMS;
         while (sent_count < budget) run_session();
      end
      quiet = 1'b0;

      drain_results();
      if (sb.errors == 0 && sb.pending_status.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
